>>> design/pnq_pkg.sv
`timescale 1ns / 1ps

package pnq_pkg;

   // sizing of the queue store
   localparam int NODE_COUNT    = 16;
   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIORITY_BITS = 8;

   // fixed field widths of the channels
   localparam int FUNC_W     = 1;
   localparam int NODE_IN_W  = 4;
   localparam int ID_W       = 4;
   localparam int PRIO_IN_W  = 8;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 4;
   localparam int QLEN_W     = 5;
   localparam int MODE_W     = 1;
   localparam int LIMIT_W    = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 5;
   localparam int CMP_W      = 8;

   // derived widths
   localparam int PRIO_W  = (PRIORITY_BITS < PRIO_IN_W) ? PRIORITY_BITS : PRIO_IN_W;
   localparam int NODE_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
   localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W  = NODE_W + SLOT_W;
   localparam int RAM_DEPTH = NODE_COUNT * (2 ** SLOT_W);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT = CSR_INDEX_W'(1);

   // request functions
   localparam logic [FUNC_W-1:0] FUNC_ENQ = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_DEQ = 1'b1;

   // scheduling modes
   localparam logic [MODE_W-1:0] MODE_FCFS = 1'b0;
   localparam logic [MODE_W-1:0] MODE_PRIO = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ENQ_CMP,
      ST_ENQ_PUT,
      ST_DEQ_CHECK,
      ST_DEQ_SHIFT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_TAIL,
      RD_BACK,
      RD_FWD
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NEW_TAIL,
      WR_NEW_SLOT,
      WR_MOVE_BACK,
      WR_MOVE_FWD
   } wr_sel_type;

   typedef enum logic [2:0] {
      SLOT_HOLD,
      SLOT_LOAD_LEN,
      SLOT_ZERO,
      SLOT_INC,
      SLOT_DEC
   } slot_op_type;

   typedef enum logic [1:0] {
      LEN_HOLD,
      LEN_INC,
      LEN_DEC
   } len_op_type;

   typedef enum logic [2:0] {
      RES_BAD_NODE,
      RES_FULL,
      RES_MISS,
      RES_ENQ_TAIL,
      RES_ENQ_SLOT,
      RES_DEQ_OK
   } res_kind_type;

   typedef struct packed {
      logic         capture;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      slot_op_type  slot_op;
      len_op_type   len_op;
      logic         res_load;
      res_kind_type res_kind;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic node_bad;
      logic is_deq;
      logic empty;
      logic full;
      logic prio_mode;
      logic tail_greater;
      logic id_match;
      logic slot_gt_one;
      logic next_in_range;
      logic len_is_one;
      logic out_free;
   } stat_type;

endpackage

>>> design/pnq_if.sv
`timescale 1ns / 1ps

interface pnq_req_if import pnq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [NODE_IN_W-1:0] node_index;
   logic [ID_W-1:0]      requester_id;
   logic [PRIO_IN_W-1:0] requester_priority;

   modport source (output valid, func, node_index, requester_id, requester_priority,
                   input ready);
   modport sink (input valid, func, node_index, requester_id, requester_priority,
                 output ready);
endinterface

interface pnq_rsp_if import pnq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    position;
   logic [QLEN_W-1:0]   queue_length;

   modport source (output valid, status, position, queue_length, input ready);
   modport sink (input valid, status, position, queue_length, output ready);
endinterface

>>> design/pnq_ram.sv
`timescale 1ns / 1ps

module pnq_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/pnq_dp.sv
`timescale 1ns / 1ps

module pnq_dp import pnq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [NODE_IN_W-1:0]   req_node_index,
   input  logic [ID_W-1:0]        req_requester_id,
   input  logic [PRIO_IN_W-1:0]   req_requester_priority,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [POS_W-1:0]       rsp_position,
   output logic [QLEN_W-1:0]      rsp_queue_length
);

   // configuration
   logic [MODE_W-1:0]  mode_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // captured request
   logic [FUNC_W-1:0]    func_ff;
   logic [NODE_IN_W-1:0] node_ff;
   logic [ID_W-1:0]      id_ff;
   logic [PRIO_W-1:0]    prio_ff;

   logic [LEN_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0] len_ff [NODE_COUNT];
   logic [LEN_W-1:0] len_in;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [POS_W-1:0]    res_pos_ff, res_pos_in;
   logic [QLEN_W-1:0]   res_len_ff, res_len_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [POS_W-1:0]    rsp_pos_ff;
   logic [QLEN_W-1:0]   rsp_len_ff;

   logic [NODE_W-1:0] node_idx;
   logic [LEN_W-1:0]  cur_len;
   logic [CMP_W-1:0]  eff_limit;
   logic [LEN_W-1:0]  rd_slot, wr_slot;
   slot_entry_type    rd_entry, wr_entry;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [ENTRY_W-1:0] rd_data;

   assign node_idx = NODE_W'(node_ff);
   assign cur_len  = len_ff[node_idx];
   assign rd_entry = slot_entry_type'(rd_data);

   assign eff_limit = (CMP_W'(limit_ff) > CMP_W'(QUEUE_DEPTH)) ?
                      CMP_W'(QUEUE_DEPTH) : CMP_W'(limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FCFS;
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:  mode_ff  <= csr_wr_data[MODE_W-1:0];
            CSR_LIMIT: limit_ff <= csr_wr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         node_ff <= req_node_index;
         id_ff   <= req_requester_id;
         prio_ff <= req_requester_priority[PRIO_W-1:0];
      end
   end

   // status toward the controller
   always_comb begin
      stat.node_bad      = (32'(node_ff) >= NODE_COUNT);
      stat.is_deq        = (func_ff == FUNC_DEQ);
      stat.empty         = (cur_len == '0);
      stat.full          = (CMP_W'(cur_len) >= eff_limit);
      stat.prio_mode     = (mode_ff == MODE_PRIO);
      stat.tail_greater  = (rd_entry.prio > prio_ff);
      stat.id_match      = (rd_entry.id == id_ff);
      stat.slot_gt_one   = (slot_ff > LEN_W'(1));
      stat.next_in_range = (LEN_W'(slot_ff + LEN_W'(1)) < cur_len);
      stat.len_is_one    = (cur_len == LEN_W'(1));
      stat.out_free      = !rsp_valid_ff || rsp_ready;
   end

   // slot store addressing
   always_comb begin
      unique case (cmd.rd_sel)
         RD_HEAD: rd_slot = '0;
         RD_TAIL: rd_slot = LEN_W'(cur_len - LEN_W'(1));
         RD_BACK: rd_slot = LEN_W'(slot_ff - LEN_W'(2));
         RD_FWD:  rd_slot = LEN_W'(slot_ff + LEN_W'(1));
         default: rd_slot = '0;
      endcase
      wr_entry.id   = id_ff;
      wr_entry.prio = prio_ff;
      unique case (cmd.wr_sel)
         WR_NEW_TAIL:  wr_slot = cur_len;
         WR_NEW_SLOT:  wr_slot = slot_ff;
         WR_MOVE_BACK: begin
            wr_slot  = slot_ff;
            wr_entry = rd_entry;
         end
         WR_MOVE_FWD: begin
            wr_slot  = LEN_W'(slot_ff - LEN_W'(1));
            wr_entry = rd_entry;
         end
         default: wr_slot = slot_ff;
      endcase
   end

   assign rd_addr = {node_idx, rd_slot[SLOT_W-1:0]};
   assign wr_addr = {node_idx, wr_slot[SLOT_W-1:0]};

   pnq_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (RAM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // slot counter
   always_comb begin
      unique case (cmd.slot_op)
         SLOT_HOLD:     slot_in = slot_ff;
         SLOT_LOAD_LEN: slot_in = cur_len;
         SLOT_ZERO:     slot_in = '0;
         SLOT_INC:      slot_in = LEN_W'(slot_ff + LEN_W'(1));
         SLOT_DEC:      slot_in = LEN_W'(slot_ff - LEN_W'(1));
         default:       slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // queue lengths
   always_comb begin
      unique case (cmd.len_op)
         LEN_INC: len_in = LEN_W'(cur_len + LEN_W'(1));
         LEN_DEC: len_in = LEN_W'(cur_len - LEN_W'(1));
         default: len_in = cur_len;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NODE_COUNT; n++) begin
            len_ff[n] <= '0;
         end
      end else if (cmd.len_op != LEN_HOLD) begin
         len_ff[node_idx] <= len_in;
      end
   end

   // result formation, from the length before this request's update
   always_comb begin
      unique case (cmd.res_kind)
         RES_BAD_NODE: begin
            res_status_in = STATUS_MISS;
            res_pos_in    = '0;
            res_len_in    = '0;
         end
         RES_FULL: begin
            res_status_in = STATUS_FULL;
            res_pos_in    = '0;
            res_len_in    = QLEN_W'(cur_len);
         end
         RES_MISS: begin
            res_status_in = STATUS_MISS;
            res_pos_in    = '0;
            res_len_in    = QLEN_W'(cur_len);
         end
         RES_ENQ_TAIL: begin
            res_status_in = STATUS_DONE;
            res_pos_in    = POS_W'(cur_len);
            res_len_in    = QLEN_W'(cur_len + LEN_W'(1));
         end
         RES_ENQ_SLOT: begin
            res_status_in = STATUS_DONE;
            res_pos_in    = POS_W'(slot_ff);
            res_len_in    = QLEN_W'(cur_len + LEN_W'(1));
         end
         RES_DEQ_OK: begin
            res_status_in = STATUS_DONE;
            res_pos_in    = '0;
            res_len_in    = QLEN_W'(cur_len - LEN_W'(1));
         end
         default: begin
            res_status_in = STATUS_MISS;
            res_pos_in    = '0;
            res_len_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= res_status_in;
         res_pos_ff    <= res_pos_in;
         res_len_ff    <= res_len_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_pos_ff    <= res_pos_ff;
         rsp_len_ff    <= res_len_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_queue_length = rsp_len_ff;

endmodule

>>> design/pnq_ctrl.sv
`timescale 1ns / 1ps

module pnq_ctrl import pnq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (stat.node_bad) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_BAD_NODE;
               state_in     = ST_FINISH;
            end else if (!stat.is_deq && stat.full) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_FULL;
               state_in     = ST_FINISH;
            end else if (!stat.is_deq && (!stat.prio_mode || stat.empty)) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_sel   = WR_NEW_TAIL;
               cmd.len_op   = LEN_INC;
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_ENQ_TAIL;
               state_in     = ST_FINISH;
            end else if (!stat.is_deq) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_TAIL;
               cmd.slot_op = SLOT_LOAD_LEN;
               state_in    = ST_ENQ_CMP;
            end else if (stat.empty) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_MISS;
               state_in     = ST_FINISH;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_HEAD;
               cmd.slot_op = SLOT_ZERO;
               state_in    = ST_DEQ_CHECK;
            end
         end
         ST_ENQ_CMP: begin
            if (stat.tail_greater) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_MOVE_BACK;
               cmd.slot_op = SLOT_DEC;
               if (stat.slot_gt_one) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_BACK;
               end else begin
                  state_in = ST_ENQ_PUT;
               end
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wr_sel   = WR_NEW_SLOT;
               cmd.len_op   = LEN_INC;
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_ENQ_SLOT;
               state_in     = ST_FINISH;
            end
         end
         ST_ENQ_PUT: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = WR_NEW_SLOT;
            cmd.len_op   = LEN_INC;
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_ENQ_SLOT;
            state_in     = ST_FINISH;
         end
         ST_DEQ_CHECK: begin
            priority if (!stat.id_match) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_MISS;
               state_in     = ST_FINISH;
            end else if (stat.len_is_one) begin
               cmd.len_op   = LEN_DEC;
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_DEQ_OK;
               state_in     = ST_FINISH;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_FWD;
               cmd.slot_op = SLOT_INC;
               state_in    = ST_DEQ_SHIFT;
            end
         end
         ST_DEQ_SHIFT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_MOVE_FWD;
            if (stat.next_in_range) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_FWD;
               cmd.slot_op = SLOT_INC;
            end else begin
               cmd.len_op   = LEN_DEC;
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_DEQ_OK;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> design/per_node_priority_wait_queues_top.sv
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// req_if    in   valid/ready    func, node_index, requester_id, requester_priority
// rsp_if    out  valid/ready    status, position, queue_length
// csr_      in   csr_wr_en      csr_index, csr_wr_data (no read-back)
//
// one request at a time; a priority-mode enqueue into a non-empty queue and a
// dequeue walk the queue in the one-read one-write slot memory, one entry per
// cycle; tail appends and refusals need no walk
// synchronous active-high reset restores config, clears queue lengths and the fsm;
// slot memory is not cleared, entries at or beyond a queue's length are never read
// a waiting response only blocks the finish step, a new request is taken meanwhile

module per_node_priority_wait_queues_top import pnq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   pnq_req_if.sink                req_if,
   pnq_rsp_if.source              rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: accepts a request, steps the shift walk, hands off the response
   pnq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: config, lengths, slot memory and the response register
   pnq_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .req_func               (req_if.func),
      .req_node_index         (req_if.node_index),
      .req_requester_id       (req_if.requester_id),
      .req_requester_priority (req_if.requester_priority),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wr_data            (csr_wr_data),
      .cmd                    (cmd),
      .stat                   (stat),
      .rsp_ready              (rsp_if.ready),
      .rsp_valid              (rsp_if.valid),
      .rsp_status             (rsp_if.status),
      .rsp_position           (rsp_if.position),
      .rsp_queue_length       (rsp_if.queue_length)
   );

endmodule

>>> design/pnq_checker.sv
`timescale 1ns / 1ps

module pnq_checker import pnq_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [POS_W-1:0]    rsp_position,
   input logic [QLEN_W-1:0]   rsp_queue_length
);

   // no response straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // only defined status codes appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_DONE || rsp_status == STATUS_FULL ||
                     rsp_status == STATUS_MISS))
      else $error("undefined status");

   // refusals and misses report slot zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DONE |-> rsp_position == '0)
      else $error("nonzero position on failed request");

   // a successful enqueue places the requester inside the new length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DONE && rsp_position != '0 |->
         QLEN_W'(rsp_position) < rsp_queue_length)
      else $error("position beyond queue length");

endmodule

bind per_node_priority_wait_queues_top pnq_checker u_pnq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_status       (rsp_if.status),
   .rsp_position     (rsp_if.position),
   .rsp_queue_length (rsp_if.queue_length)
);

>>> sim/per_node_priority_wait_queues_top_tb.sv
`timescale 1ns / 1ps

module per_node_priority_wait_queues_top_tb;
   import pnq_pkg::*;

   // cycles with no request, response or register write before the run is abandoned
   localparam int QUIET_LIMIT   = 4000;
   localparam int OPS_PER_PHASE = 125;
   localparam int RANDOM_PHASES = 10;

   // one queue operation as it waits for the request channel
   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [NODE_IN_W-1:0] node;
      logic [ID_W-1:0]      id;
      logic [PRIO_IN_W-1:0] prio;
      logic                 take_head;   // dequeue whoever heads the queue when sent
      logic [7:0]           gap;         // idle cycles after this request
   } queue_op_type;

   // what one operation reports back
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [QLEN_W-1:0]   queue_length;
   } op_outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   pnq_req_if req_if ();
   pnq_rsp_if rsp_if ();

   per_node_priority_wait_queues_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mirror of the block: node queues plus the two registers
   logic [ID_W-1:0]   mirror_id   [NODE_COUNT][QUEUE_DEPTH];
   logic [PRIO_W-1:0] mirror_prio [NODE_COUNT][QUEUE_DEPTH];
   logic [LEN_W-1:0]  mirror_len  [NODE_COUNT];
   logic [MODE_W-1:0]  mode_cfg  = MODE_FCFS;
   logic [LIMIT_W-1:0] limit_cfg = LIMIT_RESET;

   queue_op_type   op_backlog[$];           // requests not yet offered
   op_outcome_type predicted_outcomes[$];   // responses still owed by the block
   queue_op_type   op_on_bus;               // request currently offered

   int unsigned idle_left;
   int unsigned calm_req;
   int unsigned calm_rsp;
   int unsigned stall_left;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles;

   // idle length for either side; a calm stretch means no idling at all
   function automatic int unsigned idle_span(input int unsigned calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm != 0 || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // apply one accepted request to the mirror and work out its response
   function automatic op_outcome_type apply_queue_op(input queue_op_type op);
      op_outcome_type res;
      int unsigned node, len, cap, pos;
      logic [PRIO_W-1:0] prio;
      res  = '0;
      node = op.node;
      prio = op.prio[PRIO_W-1:0];
      if (node >= NODE_COUNT) begin
         res.status = STATUS_MISS;
         return res;
      end
      len = mirror_len[node];
      if (op.func == FUNC_ENQ) begin
         // a limit above the depth is capped at the depth
         cap = (limit_cfg < QUEUE_DEPTH) ? limit_cfg : QUEUE_DEPTH;
         if (len >= cap) begin
            res.status       = STATUS_FULL;
            res.queue_length = QLEN_W'(len);
         end else begin
            pos = len;
            // priority insertion: slide larger numbers back, ties keep arrival order
            if (mode_cfg == MODE_PRIO)
               while (pos > 0 && mirror_prio[node][pos-1] > prio) begin
                  mirror_id[node][pos]   = mirror_id[node][pos-1];
                  mirror_prio[node][pos] = mirror_prio[node][pos-1];
                  pos--;
               end
            mirror_id[node][pos]   = op.id;
            mirror_prio[node][pos] = prio;
            len++;
            mirror_len[node]  = LEN_W'(len);
            res.status        = STATUS_DONE;
            res.position      = POS_W'(pos);
            res.queue_length  = QLEN_W'(len);
         end
      end else if (len == 0 || mirror_id[node][0] != op.id) begin
         res.status       = STATUS_MISS;
         res.queue_length = QLEN_W'(len);
      end else begin
         for (int k = 1; k < len; k++) begin
            mirror_id[node][k-1]   = mirror_id[node][k];
            mirror_prio[node][k-1] = mirror_prio[node][k];
         end
         len--;
         mirror_len[node] = LEN_W'(len);
         res.status       = STATUS_DONE;
         res.queue_length = QLEN_W'(len);
      end
      return res;
   endfunction

   // add a request to the backlog, with calm stretches now and then
   function automatic void queue_op(input logic [FUNC_W-1:0] func, input int unsigned node,
                                    input int unsigned id, input int unsigned prio,
                                    input logic take_head);
      queue_op_type op;
      if (calm_req != 0) calm_req--;
      else if ($urandom_range(0, 39) == 0) calm_req = $urandom_range(15, 40);
      op.func      = func;
      op.node      = NODE_IN_W'(node);
      op.id        = ID_W'(id);
      op.prio      = PRIO_IN_W'(prio);
      op.take_head = take_head;
      op.gap       = 8'(idle_span(calm_req));
      op_backlog.push_back(op);
   endfunction

   // register write: one cycle of enable, then the mirror takes the value
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_MODE) mode_cfg = data[MODE_W-1:0];
      else limit_cfg = data[LIMIT_W-1:0];
   endtask

   // wait until every request is out and every response is back, then let the fsm settle
   task automatic drain_queues();
      do @(negedge clock);
      while (op_backlog.size() != 0 || req_if.valid || predicted_outcomes.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // request driver: predict on acceptance, then offer the next request
   always @(posedge clock) begin : feed_requests
      queue_op_type op;
      if (reset) begin
         req_if.valid <= 1'b0;
         idle_left = 0;
         for (int n = 0; n < NODE_COUNT; n++) mirror_len[n] = '0;
      end else begin
         if (req_if.valid && req_if.ready)
            predicted_outcomes.push_back(apply_queue_op(op_on_bus));
         // bus is free when nothing is offered or the offer was just taken
         if (!req_if.valid || req_if.ready) begin
            if (idle_left != 0) begin
               idle_left--;
               req_if.valid <= 1'b0;
            end else if (op_backlog.size() != 0) begin
               op = op_backlog.pop_front();
               // well-formed dequeue: name the head as the mirror sees it right now
               if (op.take_head && mirror_len[op.node] != 0)
                  op.id = mirror_id[op.node][0];
               op_on_bus = op;
               idle_left = op.gap;
               req_if.valid              <= 1'b1;
               req_if.func               <= op.func;
               req_if.node_index         <= op.node;
               req_if.requester_id       <= op.id;
               req_if.requester_priority <= op.prio;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: check against the oldest prediction, stall at random
   always @(posedge clock) begin : check_responses
      op_outcome_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         calm_rsp   = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.status       = rsp_if.status;
            got.position     = rsp_if.position;
            got.queue_length = rsp_if.queue_length;
            if (predicted_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response with no request outstanding: status %0d position %0d length %0d",
                           $time, got.status, got.position, got.queue_length);
            end else begin
               want = predicted_outcomes.pop_front();
               if (got.status !== want.status || got.position !== want.position ||
                   got.queue_length !== want.queue_length) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch: expected status %0d position %0d length %0d, got status %0d position %0d length %0d",
                              $time, want.status, want.position, want.queue_length,
                              got.status, got.position, got.queue_length);
               end
            end
         end
         if (calm_rsp != 0) calm_rsp--;
         else if ($urandom_range(0, 49) == 0) calm_rsp = $urandom_range(20, 60);
         if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_span(calm_rsp);
         end
      end
   end

   // watchdog: a hang shows up as a long run of cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_wr_en)
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("per_node_priority_wait_queues_top regression: fail");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // stimulus
   initial begin : stimulus
      int unsigned hot [3];
      int unsigned node, prio, enq_pct, r;
      logic [MODE_W-1:0]     mode_plan  [RANDOM_PHASES];
      logic [LIMIT_W-1:0]    limit_plan [RANDOM_PHASES];
      logic [CSR_DATA_W-1:0] mode_word;

      // every block input known from time zero
      reset                     = 1'b1;
      csr_wr_en                 = 1'b0;
      csr_index                 = CSR_MODE;
      csr_wr_data               = '0;
      req_if.valid              = 1'b0;
      req_if.func               = FUNC_ENQ;
      req_if.node_index         = '0;
      req_if.requester_id       = '0;
      req_if.requester_priority = '0;
      rsp_if.ready              = 1'b0;
      calm_req                  = 0;
      quiet_cycles              = 0;

      mode_plan  = '{MODE_PRIO, MODE_FCFS, MODE_PRIO, MODE_PRIO, MODE_FCFS,
                     MODE_PRIO, MODE_FCFS, MODE_PRIO, MODE_FCFS, MODE_PRIO};
      limit_plan = '{5'd16, 5'd1, 5'd4, 5'd2, 5'd16, 5'd31, 5'd3, 5'd17, 5'd8, 5'd16};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: fcfs, limit 16
      // dequeue of an empty queue, then a requester not at the head
      queue_op(FUNC_DEQ, 0, 0, 0, 1'b0);
      queue_op(FUNC_ENQ, 15, 15, 255, 1'b0);
      queue_op(FUNC_ENQ, 15, 0, 0, 1'b0);
      queue_op(FUNC_DEQ, 15, 0, 0, 1'b0);
      queue_op(FUNC_DEQ, 15, 15, 255, 1'b0);
      queue_op(FUNC_DEQ, 15, 0, 0, 1'b0);
      queue_op(FUNC_DEQ, 15, 0, 0, 1'b0);
      drain_queues();

      // priority mode with a limit above the depth: fill node 3 past full
      write_reg(CSR_MODE, 5'b11111);
      write_reg(CSR_LIMIT, 5'd31);
      for (int i = 0; i < QUEUE_DEPTH + 1; i++)
         queue_op(FUNC_ENQ, 3, i, ((i * 37) % 8) * 36, 1'b0);
      drain_queues();

      // limit of zero refuses every enqueue, full or empty; dequeue still works
      write_reg(CSR_MODE, 5'b00000);
      write_reg(CSR_LIMIT, 5'd0);
      queue_op(FUNC_ENQ, 3, 9, 1, 1'b0);
      queue_op(FUNC_ENQ, 7, 2, 128, 1'b0);
      queue_op(FUNC_DEQ, 3, 0, 0, 1'b1);
      drain_queues();

      // random phases: mostly well-formed traffic on a few busy nodes
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         mode_word    = CSR_DATA_W'($urandom);
         mode_word[0] = mode_plan[ph];
         write_reg(CSR_MODE, mode_word);
         write_reg(CSR_LIMIT, limit_plan[ph]);
         for (int h = 0; h < 3; h++) hot[h] = $urandom_range(0, NODE_COUNT - 1);
         enq_pct = $urandom_range(35, 70);
         repeat (OPS_PER_PHASE) begin
            node = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 2)]
                                               : $urandom_range(0, 15);
            r = $urandom_range(0, 9);
            // narrow priorities make plenty of ties
            prio = (r < 5) ? $urandom_range(0, 7) : (r < 8) ? $urandom_range(0, 255) :
                   (r == 8) ? 0 : 255;
            if ($urandom_range(0, 99) < enq_pct)
               queue_op(FUNC_ENQ, node, $urandom_range(0, 15), prio, 1'b0);
            else
               // one dequeue in five names a random requester
               queue_op(FUNC_DEQ, node, $urandom_range(0, 15), prio,
                        $urandom_range(0, 4) != 0);
         end
         drain_queues();
      end

      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("per_node_priority_wait_queues_top regression: pass");
      else
         $display("per_node_priority_wait_queues_top regression: fail");
      $finish;
   end

endmodule

>>> per_node_priority_wait_queues_top.f
design/pnq_pkg.sv
design/pnq_if.sv
design/pnq_ram.sv
design/pnq_dp.sv
design/pnq_ctrl.sv
design/per_node_priority_wait_queues_top.sv
design/pnq_checker.sv
sim/per_node_priority_wait_queues_top_tb.sv
